@@ src/packet_framer_crc32_assert.svh @@
// Assertion macros used by the packet framer top level.
`ifndef PACKET_FRAMER_CRC32_ASSERT_SVH
`define PACKET_FRAMER_CRC32_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PFC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PFC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/pfc_pkg.sv @@
// Package: types, constants and CRC/header helpers for the packet framer.
package pfc_pkg;

	localparam int HDR_BYTES   = 8;
	localparam int CRC_BYTES   = 4;
	localparam int MAX_PAYLOAD = 512;
	localparam int IDX_W       = $clog2(HDR_BYTES);
	localparam int QDEPTH      = 4;
	localparam int QAW         = $clog2(QDEPTH);
	localparam int QCW         = $clog2(QDEPTH + 1);

	localparam logic [31:0]      CRC_POLY  = 32'hEDB88320;
	localparam logic [31:0]      CRC_INIT  = 32'hFFFFFFFF;
	localparam logic [9:0]       COUNT_MAX = 10'd1023;
	localparam logic [IDX_W-1:0] HDR_LAST  = IDX_W'(HDR_BYTES - 1);
	localparam logic [IDX_W-1:0] CRC_LAST  = IDX_W'(CRC_BYTES - 1);

	// one accepted word as held in the queue
	typedef struct packed {
		logic        first_item;
		logic        last_item;
		logic        has_byte;
		logic [7:0]  payload_byte;
		logic [2:0]  ptype;
		logic [4:0]  window_size;
		logic [7:0]  seq_num;
		logic [9:0]  pay_len;
		logic [31:0] time_stamp;
	} pfc_entry_t;

	typedef struct packed {
		logic           empty;
		logic           full;
		logic [QCW-1:0] count;
	} pfc_qstat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HDR,
		ST_PAY,
		ST_CRC
	} pfc_state_t;

	// reflected CRC-32, one byte, LSB first
	function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'h0, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	function automatic logic [7:0] hdr_byte(input pfc_entry_t e, input logic [IDX_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0:    b = {e.ptype, e.window_size};
			3'd1:    b = e.seq_num;
			3'd2:    b = {6'h0, e.pay_len[9:8]};
			3'd3:    b = e.pay_len[7:0];
			3'd4:    b = e.time_stamp[7:0];
			3'd5:    b = e.time_stamp[15:8];
			3'd6:    b = e.time_stamp[23:16];
			3'd7:    b = e.time_stamp[31:24];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

@@ src/pfc_front.sv @@
// Front end: accepts input words, drops those outside a frame or with no flags set, tracks frame open.
module pfc_front import pfc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       first_item,
	input  logic       last_item,
	input  logic       has_byte,
	input  logic [7:0] payload_byte,
	input  logic [2:0] ptype,
	input  logic [4:0] window_size,
	input  logic [7:0] seq_num,
	input  logic [9:0] pay_len,
	input  logic [31:0] time_stamp,
	input  logic       q_full,
	output logic       push,
	output pfc_entry_t push_entry
);

	logic in_frame_q;
	logic accept;
	logic keep;
	logic emits;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign keep     = first_item || in_frame_q;
	// a word in an open frame with no flags set yields no bytes
	assign emits    = first_item || has_byte || last_item;
	assign push     = accept && keep && emits;

	always_comb begin
		push_entry.first_item   = first_item;
		push_entry.last_item    = last_item;
		push_entry.has_byte     = has_byte;
		push_entry.payload_byte = payload_byte;
		push_entry.ptype        = ptype;
		push_entry.window_size  = window_size;
		push_entry.seq_num      = seq_num;
		push_entry.pay_len      = pay_len;
		push_entry.time_stamp   = time_stamp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
		end else if (accept && keep) begin
			in_frame_q <= !last_item;
		end
	end

endmodule

@@ src/pfc_queue.sv @@
// Short word queue between front end and byte sequencer.
module pfc_queue import pfc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  pfc_entry_t push_entry,
	input  logic       pop,
	output pfc_entry_t head,
	output pfc_qstat_t stat
);

	pfc_entry_t     mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == QCW'(QDEPTH));
	assign stat.count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

endmodule

@@ src/pfc_back.sv @@
// Back end: expands queued words into header, payload and CRC bytes.
module pfc_back import pfc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  pfc_entry_t head,
	input  pfc_qstat_t qstat,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       frame_end,
	output logic       length_error
);

	pfc_state_t       state_q, state_d;
	pfc_state_t       start_st, cur_st;
	logic [IDX_W-1:0] idx_q, idx_d, cur_idx;
	logic [31:0]      crc_q, crc_d, crc_fin;
	logic [9:0]       cnt_q, cnt_d;
	logic [9:0]       decl_q, decl_d;
	logic             over_q, over_d;
	logic             fire;
	logic [7:0]       byte_d;
	logic             end_d;
	logic             err_d;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             frame_end_q;
	logic             length_error_q;

	// a fresh word starts at its first step in the same cycle
	always_comb begin
		if (head.first_item) begin
			start_st = ST_HDR;
		end else if (head.has_byte) begin
			start_st = ST_PAY;
		end else begin
			start_st = ST_CRC;
		end
		cur_st  = (state_q == ST_IDLE) ? start_st : state_q;
		cur_idx = (state_q == ST_IDLE) ? '0 : idx_q;
	end

	assign fire    = !qstat.empty && (!out_valid_q || out_ready);
	assign crc_fin = ~crc_q;

	// next state
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		pop     = 1'b0;
		if (fire) begin
			case (cur_st)
				ST_HDR: begin
					if (cur_idx == HDR_LAST) begin
						idx_d = '0;
						if (head.has_byte) begin
							state_d = ST_PAY;
						end else if (head.last_item) begin
							state_d = ST_CRC;
						end else begin
							state_d = ST_IDLE;
							pop     = 1'b1;
						end
					end else begin
						state_d = ST_HDR;
						idx_d   = cur_idx + IDX_W'(1);
					end
				end
				ST_PAY: begin
					idx_d = '0;
					if (head.last_item) begin
						state_d = ST_CRC;
					end else begin
						state_d = ST_IDLE;
						pop     = 1'b1;
					end
				end
				ST_CRC: begin
					if (cur_idx == CRC_LAST) begin
						state_d = ST_IDLE;
						idx_d   = '0;
						pop     = 1'b1;
					end else begin
						state_d = ST_CRC;
						idx_d   = cur_idx + IDX_W'(1);
					end
				end
				default: begin
					state_d = ST_IDLE;
					idx_d   = '0;
				end
			endcase
		end
	end

	// outputs and datapath
	always_comb begin
		byte_d = 8'h00;
		end_d  = 1'b0;
		err_d  = 1'b0;
		crc_d  = crc_q;
		cnt_d  = cnt_q;
		over_d = over_q;
		decl_d = decl_q;
		case (cur_st)
			ST_HDR: begin
				byte_d = hdr_byte(head, cur_idx);
				if (cur_idx == '0) begin
					crc_d  = crc32_byte(CRC_INIT, byte_d);
					cnt_d  = '0;
					over_d = 1'b0;
					decl_d = head.pay_len;
				end else begin
					crc_d = crc32_byte(crc_q, byte_d);
				end
			end
			ST_PAY: begin
				byte_d = head.payload_byte;
				crc_d  = crc32_byte(crc_q, byte_d);
				if (cnt_q == COUNT_MAX) begin
					over_d = 1'b1;
				end else begin
					cnt_d = cnt_q + 10'd1;
				end
			end
			ST_CRC: begin
				case (cur_idx[1:0])
					2'd0:    byte_d = crc_fin[31:24];
					2'd1:    byte_d = crc_fin[23:16];
					2'd2:    byte_d = crc_fin[15:8];
					default: byte_d = crc_fin[7:0];
				endcase
				end_d = (cur_idx == CRC_LAST);
				err_d = end_d && (over_q || (cnt_q != decl_q) ||
					(decl_q > 10'(MAX_PAYLOAD)));
			end
			default: begin
				byte_d = 8'h00;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			crc_q   <= CRC_INIT;
			cnt_q   <= '0;
			over_q  <= 1'b0;
			decl_q  <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (fire) begin
				crc_q  <= crc_d;
				cnt_q  <= cnt_d;
				over_q <= over_d;
				decl_q <= decl_d;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q     <= byte_d;
			frame_end_q    <= end_d;
			length_error_q <= err_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign frame_end    = frame_end_q;
	assign length_error = length_error_q;

endmodule

@@ src/packet_framer_crc32.sv @@
// Top level of the packet framer with CRC-32 trailer.
// Turns packet words into a framed byte stream. A word with first_item set
// opens a frame and yields an 8-byte header (type/window, sequence number,
// big-endian length, little-endian timestamp); each word with has_byte set
// yields its payload byte; a word with last_item set closes the frame with
// the reflected CRC-32 (init and final xor all ones) over header and payload,
// MSB first. frame_end marks the last CRC byte and length_error on it flags a
// payload count that differs from pay_len, a count past 1023, or a pay_len
// above 512. Words arriving while no frame is open (and not opening one) are
// swallowed. The output side emits one byte per clock unless out_ready stalls
// it; a word yields one byte if it is a plain payload word, up to 13 if it
// opens and closes a frame. The input side accepts one word per clock while
// the 4-word queue has room, so header and CRC bursts are absorbed and, with
// out_ready held, the sustained payload rate is one word per cycle. A word
// entering an empty queue reaches out_byte via the queue and output register.
module packet_framer_crc32 import pfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input word channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        first_item,
	input  logic        last_item,
	input  logic        has_byte,
	input  logic [7:0]  payload_byte,
	input  logic [2:0]  ptype,
	input  logic [4:0]  window_size,
	input  logic [7:0]  seq_num,
	input  logic [9:0]  pay_len,
	input  logic [31:0] time_stamp,
	// output byte channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        frame_end,
	output logic        length_error
);

	`include "packet_framer_crc32_assert.svh"

	logic       q_push;
	logic       q_pop;
	pfc_entry_t q_wdata;
	pfc_entry_t q_head;
	pfc_qstat_t q_stat;

	// front: accept and filter words
	pfc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.first_item   (first_item),
		.last_item    (last_item),
		.has_byte     (has_byte),
		.payload_byte (payload_byte),
		.ptype        (ptype),
		.window_size  (window_size),
		.seq_num      (seq_num),
		.pay_len      (pay_len),
		.time_stamp   (time_stamp),
		.q_full       (q_stat.full),
		.push         (q_push),
		.push_entry   (q_wdata)
	);

	// decoupling queue
	pfc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_wdata),
		.pop        (q_pop),
		.head       (q_head),
		.stat       (q_stat)
	);

	// back: byte sequencer, CRC and length check
	pfc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.qstat        (q_stat),
		.pop          (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.frame_end    (frame_end),
		.length_error (length_error)
	);

	// checks
	`PFC_ASSERT_IMP(a_no_overflow, q_push && !q_pop, !q_stat.full, "queue overflow")
	`PFC_ASSERT_IMP(a_no_underflow, q_pop, !q_stat.empty, "pop from empty queue")
	`PFC_ASSERT_IMP(a_err_on_end, out_valid && length_error, frame_end, "length_error off frame end")
	`PFC_ASSERT_NXT(a_pop_count, q_pop && !q_push, q_stat.count == $past(q_stat.count) - 3'd1, "queue count slip")

endmodule
